[design/crr_pkg.sv]
// Package: shared types and codes for the cascaded range remap unit.
package crr_pkg;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  stage_index;
    logic [5:0]  slot_index;
    logic [31:0] source_start;
    logic [31:0] dest_start;
    logic [31:0] span_length;
    logic        entry_enable;
    logic [31:0] query_value;
  } crr_in_t;

  typedef struct packed {
    logic [31:0] final_value;
    logic [31:0] lowest_value;
  } crr_out_t;

  typedef struct packed {
    logic        en;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] len;
  } crr_entry_t;

endpackage

[design/cascaded_range_remap_unit.sv]
// Top level: cascaded range remap unit with one shared entry memory scanned per stage.
//
//  channel   direction  handshake           word
//  command   in         start_i / busy_o    cmd_i   (crr_in_t)
//  result    out        valid_o strobe      res_o   (crr_out_t)
//
// A write, clear or ignored command leaves the unit idle; busy stays low after it.
// A query scans the stages in turn: the single entry memory port reads one slot
// a cycle, and each stage ends with a read-latency step and an apply step;
// the done state then registers the result.
// Reset sets the running minimum to all ones and starts a clearing pass over
// all STAGE_COUNT * SLOTS_PER_STAGE entries (448 with the defaults); busy_o is high
// until every entry is invalid.
// The receiver cannot stall: the result is shown for one cycle with valid_o.
module cascaded_range_remap_unit import crr_pkg::*; #(
  parameter int STAGE_COUNT     = 7,
  parameter int SLOTS_PER_STAGE = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  crr_in_t  cmd_i,
  output logic     busy_o,
  output logic     valid_o,
  output crr_out_t res_o
);

  localparam int Depth  = STAGE_COUNT * SLOTS_PER_STAGE;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SlotW  = (SLOTS_PER_STAGE > 1) ? $clog2(SLOTS_PER_STAGE) : 1;
  localparam int StageW = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  crr_entry_t mem_q [Depth];

  logic [1:0]        state_q, state_d;
  logic [StageW-1:0] stage_q, stage_d;
  logic [SlotW:0]    slot_q, slot_d;
  logic [31:0]       value_q, value_d;
  logic [31:0]       lowest_q, lowest_d;
  logic              found_q, found_d;
  crr_entry_t        pick_q, pick_d;
  crr_entry_t        rd_q;
  logic              rd_vld_q;
  logic              clear_q;
  logic [AddrW-1:0]  clr_addr_q;
  logic [AddrW-1:0]  rd_addr, wr_addr;
  logic              wr_ok, accept;
  logic [31:0]       off;
  logic              valid_d;

  assign busy_o  = clear_q || (state_q != ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign wr_addr = AddrW'(32'(cmd_i.stage_index) * SLOTS_PER_STAGE + 32'(cmd_i.slot_index));
  assign wr_ok   = accept && (cmd_i.kind == KIND_WRITE) &&
                   (32'(cmd_i.stage_index) < STAGE_COUNT) &&
                   (32'(cmd_i.slot_index) < SLOTS_PER_STAGE);
  assign rd_addr = AddrW'(32'(stage_q) * SLOTS_PER_STAGE + 32'(slot_q[SlotW-1:0]));

  always_ff @(posedge clk_i) begin
    if (clear_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_ok) begin
      mem_q[wr_addr] <= '{en: cmd_i.entry_enable, src: cmd_i.source_start,
                          dst: cmd_i.dest_start, len: cmd_i.span_length};
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q    <= 1'b1;
      clr_addr_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (clear_q) begin
        if (32'(clr_addr_q) == Depth - 1) begin
          clear_q <= 1'b0;
        end
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      rd_vld_q <= (state_q == ST_SCAN) && (32'(slot_q) < SLOTS_PER_STAGE);
    end
  end

  assign off = value_q - pick_q.src;

  always_comb begin
    state_d  = state_q;
    stage_d  = stage_q;
    slot_d   = slot_q;
    value_d  = value_q;
    lowest_d = lowest_q;
    found_d  = found_q;
    pick_d   = pick_q;
    valid_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i.kind == KIND_QUERY) begin
            value_d = cmd_i.query_value;
            stage_d = '0;
            slot_d  = '0;
            found_d = 1'b0;
            state_d = ST_SCAN;
          end else if (cmd_i.kind == KIND_CLEAR) begin
            lowest_d = '1;
          end
        end
      end
      ST_SCAN: begin
        if (rd_vld_q && rd_q.en && (rd_q.src <= value_q) &&
            (!found_q || rd_q.src > pick_q.src)) begin
          found_d = 1'b1;
          pick_d  = rd_q;
        end
        if (32'(slot_q) < SLOTS_PER_STAGE) begin
          slot_d = slot_q + 1'b1;
        end else begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (found_q && (off < pick_q.len)) begin
          value_d = pick_q.dst + off;
        end
        found_d = 1'b0;
        slot_d  = '0;
        if (32'(stage_q) == STAGE_COUNT - 1) begin
          state_d = ST_DONE;
        end else begin
          stage_d = stage_q + 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_DONE: begin
        if (value_q < lowest_q) begin
          lowest_d = value_q;
        end
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      stage_q  <= '0;
      slot_q   <= '0;
      found_q  <= 1'b0;
      lowest_q <= '1;
      valid_o  <= 1'b0;
    end else begin
      state_q  <= state_d;
      stage_q  <= stage_d;
      slot_q   <= slot_d;
      found_q  <= found_d;
      lowest_q <= lowest_d;
      valid_o  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pick_q  <= pick_d;
    if (valid_d) begin
      res_o.final_value  <= value_q;
      res_o.lowest_value <= lowest_d;
    end
  end

endmodule

[tb/cascaded_range_remap_unit_tb.sv]
// Testbench: random and directed command words checked against a range remap predictor.
module cascaded_range_remap_unit_tb import crr_pkg::*;;

  localparam int NSTAGE = 7;
  localparam int NSLOT  = 64;
  localparam int WATCHDOG_LIMIT = 4000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start_i = 1'b0;
  crr_in_t  cmd_i = '0;
  logic     busy_o;
  logic     valid_o;
  crr_out_t res_o;

  cascaded_range_remap_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .cmd_i(cmd_i),
    .busy_o(busy_o), .valid_o(valid_o), .res_o(res_o)
  );

  always #4 clk_i = ~clk_i;

  logic [31:0] map_src [NSTAGE*NSLOT];
  logic [31:0] map_dst [NSTAGE*NSLOT];
  logic [31:0] map_len [NSTAGE*NSLOT];
  logic        map_on  [NSTAGE*NSLOT];
  logic [31:0] min_seen;
  crr_out_t    remap_expected [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  logic [31:0] pool [$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic logic [31:0] remap_through(input logic [31:0] v);
    logic [31:0] cur;
    logic        hit;
    int          pick;
    int          e;
    cur = v;
    for (int st = 0; st < NSTAGE; st++) begin
      hit = 1'b0;
      pick = 0;
      for (int s = 0; s < NSLOT; s++) begin
        e = st*NSLOT + s;
        if (map_on[e] && map_src[e] <= cur && (!hit || map_src[e] > map_src[pick])) begin
          hit = 1'b1;
          pick = e;
        end
      end
      if (hit && (cur - map_src[pick]) < map_len[pick]) cur = map_dst[pick] + (cur - map_src[pick]);
    end
    return cur;
  endfunction

  task automatic predict(input crr_in_t c);
    crr_out_t r;
    int e;
    if (c.kind == KIND_WRITE) begin
      if (c.stage_index < NSTAGE) begin
        e = c.stage_index*NSLOT + c.slot_index;
        map_src[e] = c.source_start;
        map_dst[e] = c.dest_start;
        map_len[e] = c.span_length;
        map_on[e] = c.entry_enable;
      end
    end else if (c.kind == KIND_QUERY) begin
      r.final_value = remap_through(c.query_value);
      if (r.final_value < min_seen) min_seen = r.final_value;
      r.lowest_value = min_seen;
      remap_expected.push_back(r);
    end else if (c.kind == KIND_CLEAR) begin
      min_seen = '1;
    end
  endtask

  function automatic crr_in_t blank_word(input logic [1:0] k);
    crr_in_t c;
    c.kind = k;
    c.stage_index = 3'($urandom);
    c.slot_index = 6'($urandom);
    c.source_start = $urandom;
    c.dest_start = $urandom;
    c.span_length = $urandom;
    c.entry_enable = 1'($urandom);
    c.query_value = $urandom;
    return c;
  endfunction

  task automatic send_word(input crr_in_t c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        start_i <= 1'b0;
        cmd_i <= blank_word(2'($urandom));
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start_i <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict(c);
    @(negedge clk_i);
  endtask

  task automatic write_entry(input int st, input int sl, input logic [31:0] s,
                             input logic [31:0] d, input logic [31:0] l, input logic en);
    crr_in_t c;
    c = blank_word(KIND_WRITE);
    c.stage_index = st[2:0];
    c.slot_index = sl[5:0];
    c.source_start = s;
    c.dest_start = d;
    c.span_length = l;
    c.entry_enable = en;
    send_word(c);
  endtask

  task automatic query(input logic [31:0] v);
    crr_in_t c;
    c = blank_word(KIND_QUERY);
    c.query_value = v;
    send_word(c);
  endtask

  always @(posedge clk_i) begin
    if (valid_o) begin
      if (remap_expected.size() == 0) begin
        report("unexpected result", res_o.final_value, 32'h0);
      end else begin
        if (res_o.final_value !== remap_expected[0].final_value)
          report("final_value", res_o.final_value, remap_expected[0].final_value);
        if (res_o.lowest_value !== remap_expected[0].lowest_value)
          report("lowest_value", res_o.lowest_value, remap_expected[0].lowest_value);
        void'(remap_expected.pop_front());
      end
    end
    if (valid_o || (start_i && !busy_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    crr_in_t c;
    query(32'h0);
    query(32'hFFFF_FFFF);
    write_entry(0, 0, 32'd10, 32'd100, 32'd5, 1'b1);
    write_entry(0, 1, 32'd10, 32'd900, 32'd5, 1'b1);
    query(32'd9);
    query(32'd10);
    query(32'd14);
    query(32'd15);
    write_entry(1, 63, 32'd100, 32'd0, 32'd0, 1'b1);
    query(32'd12);
    write_entry(6, 5, 32'hFFFF_FFF0, 32'h1, 32'hFFFF_FFFF, 1'b1);
    query(32'hFFFF_FFFF);
    write_entry(7, 0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1);
    query(32'h5);
    c = blank_word(2'd3);
    send_word(c);
    c = blank_word(KIND_CLEAR);
    send_word(c);
    query(32'd11);
    write_entry(0, 1, 32'd10, 32'd900, 32'd5, 1'b0);
    write_entry(0, 0, 32'd10, 32'd100, 32'd5, 1'b0);
    query(32'd11);
  endtask

  task automatic test_random();
    crr_in_t c;
    int n;
    int pk;
    n = 0;
    while (n < 680) begin
      pk = $urandom_range(0, 99);
      if (pk < 55) begin
        c = blank_word(KIND_WRITE);
        c.stage_index = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
        c.slot_index = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
        if ($urandom_range(0, 3) != 0) begin
          c.source_start = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000);
          c.dest_start = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000);
          c.span_length = $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 800);
          pool.push_back(c.source_start);
        end
        c.entry_enable = $urandom_range(0, 4) != 0;
        if (c.kind == KIND_WRITE) n++;
      end else if (pk < 93) begin
        c = blank_word(KIND_QUERY);
        if (pool.size() > 0 && $urandom_range(0, 2) != 0)
          c.query_value = pool[$urandom_range(0, pool.size()-1)] + $urandom_range(0, 900) - 50;
        else if ($urandom_range(0, 1)) c.query_value = $urandom_range(0, 5000);
        n++;
      end else if (pk < 97) begin
        c = blank_word(KIND_CLEAR);
        n++;
      end else begin
        c = blank_word(2'd3);
      end
      send_word(c);
    end
  endtask

  initial begin
    for (int i = 0; i < NSTAGE*NSLOT; i++) begin
      map_on[i] = 1'b0;
      map_src[i] = '0;
      map_dst[i] = '0;
      map_len[i] = '0;
    end
    min_seen = '1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    start_i <= 1'b0;
    while (remap_expected.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    if (mismatches == 0 && remap_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
